// File: design/assert_macros.svh
// Assertion helpers included by the erfinv core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is off while reset is high.
`define ERF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check in the cycle after the trigger condition.
`define ERF_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: design/erfinv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erfinv_pkg
// Shared types, constants and rounding helper for the inverse error function.
// ----------------------------------------------------------------------------
package erfinv_pkg;

   localparam int XW          = 32;   // argument / result width
   localparam int PW          = 40;   // Horner accumulator, Q.32
   localparam int TW          = 29;   // polynomial variable, Q.26
   localparam int RW          = 80;   // rounding work width
   localparam int LOG_ITERS   = 28;
   localparam int SQRT_ITERS  = 32;
   localparam int HORNER_STEPS = 8;

   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [32:0] FIVE_Q28 = 33'd5 << 28;
   localparam logic signed [33:0] HALF5_Q26 = 34'sd5 <<< 25;
   localparam logic signed [29:0] THREE_Q26 = 30'sd3 <<< 26;
   localparam logic [XW-1:0] MINUS_ONE = 32'h8000_0000;
   localparam logic signed [XW-1:0] INT_MAX = 32'sh7fff_ffff;
   localparam logic signed [XW-1:0] INT_MIN = 32'sh8000_0000;

   typedef logic signed [PW-1:0] coef_arr_type [0:HORNER_STEPS];

   localparam coef_arr_type SMALL_COEF = '{
      40'sd121, 40'sd1474, -40'sd15133, -40'sd18861, 40'sd938798,
      -40'sd5384708, -40'sd17943006, 40'sd1059313856, 40'sd6448504314
   };

   localparam coef_arr_type LARGE_COEF = '{
      -40'sd859914, 40'sd433579, 40'sd5795385, -40'sd15777255, 40'sd24650998,
      -40'sd32738222, 40'sd40539640, 40'sd4302157329, 40'sd12167542792
   };

   typedef struct packed {
      logic                 valid;
      logic                 sat;
      logic signed [XW-1:0] x;
   } item_type;

   typedef struct packed {
      item_type             item;
      logic                 big;
      logic signed [TW-1:0] t;
   } horner_type;

   // Shift right by s, round half away from zero.
   function automatic logic signed [RW-1:0] round_shift(input logic signed [RW-1:0] v,
                                                        input logic [6:0] s);
      logic [RW-1:0] half;
      logic [RW-1:0] mag;
      logic [RW-1:0] q;
      half = RW'(1) << (s - 7'd1);
      if (v[RW-1]) begin
         mag = RW'(-v);
         q = (mag + half) >> s;
         round_shift = -$signed(q);
      end else begin
         q = (RW'(v) + half) >> s;
         round_shift = $signed(q);
      end
   endfunction

endpackage
`default_nettype wire

// File: design/erfinv_horner_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erfinv_horner_step
// One Horner step p = c + round(p * t / 2^26), as a multiply stage and an
// accumulate stage.
// ----------------------------------------------------------------------------
module erfinv_horner_step (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire erfinv_pkg::horner_type            hd_in,
   input  wire logic signed [erfinv_pkg::PW-1:0]  p_in,
   input  wire logic signed [erfinv_pkg::PW-1:0]  coef_small,
   input  wire logic signed [erfinv_pkg::PW-1:0]  coef_large,
   output erfinv_pkg::horner_type                 hd_out,
   output logic signed [erfinv_pkg::PW-1:0]       p_out
);
   import erfinv_pkg::*;

   horner_type                 mul_hd_ff;
   logic signed [PW+TW-1:0]    mul_prod_ff;
   logic signed [PW+TW-1:0]    mul_prod_in;
   horner_type                 acc_hd_ff;
   logic signed [PW-1:0]       acc_p_ff;
   logic signed [PW-1:0]       acc_p_in;
   logic signed [RW-1:0]       prod_ext;
   logic signed [RW-1:0]       prod_rnd;

   assign mul_prod_in = (PW+TW)'(p_in) * (PW+TW)'(hd_in.t);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_hd_ff.item.valid <= 1'b0;
      end else if (en) begin
         mul_hd_ff   <= hd_in;
         mul_prod_ff <= mul_prod_in;
      end
   end

   always_comb begin
      prod_ext = RW'(mul_prod_ff);
      prod_rnd = round_shift(prod_ext, 7'd26);
      acc_p_in = (mul_hd_ff.big ? coef_large : coef_small) + prod_rnd[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_hd_ff.item.valid <= 1'b0;
      end else if (en) begin
         acc_hd_ff <= mul_hd_ff;
         acc_p_ff  <= acc_p_in;
      end
   end

   assign hd_out = acc_hd_ff;
   assign p_out  = acc_p_ff;

endmodule
`default_nettype wire

// File: design/inverse_error_function_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_error_function_core
// erfinv(x) for a Q0.31 argument, Q3.28 result, single-precision polynomial
// scheme with fixed-point log and square root.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock when not stalled. The pipe holds the
// 28-stage square-and-compare log2, the 32-stage digit square root and the 8
// Horner steps (two stages each). The whole pipe advances when the result
// register is empty or being taken; a held result stalls every stage in place.
// An argument of -1 returns the most negative value with rsp_tuser set.
module inverse_error_function_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] x_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] inv_erf
   output logic             rsp_tuser    // [0] saturated
);
   import erfinv_pkg::*;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------- square of the magnitude ----------------
   item_type    s1_item_ff, s1_item_in;
   logic [62:0] s1_sq_ff, s1_sq_in;
   logic [31:0] mag;

   always_comb begin
      s1_item_in.valid = req_tvalid;
      s1_item_in.x     = $signed(req_tdata);
      s1_item_in.sat   = (req_tdata == MINUS_ONE);
      mag = req_tdata[31] ? 32'(-req_tdata) : req_tdata;
      s1_sq_in = 63'(mag) * 63'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_item_ff.valid <= 1'b0;
      end else if (en) begin
         s1_item_ff <= s1_item_in;
         s1_sq_ff   <= s1_sq_in;
      end
   end

   // ---------------- v = 1 - x^2, Q0.62 ----------------
   item_type    s2_item_ff;
   logic [62:0] s2_v_ff, s2_v_in;

   assign s2_v_in = (63'd1 << 62) - s1_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_item_ff.valid <= 1'b0;
      end else if (en) begin
         s2_item_ff <= s1_item_ff;
         s2_v_ff    <= s2_v_in;
      end
   end

   // ---------------- normalize to Q1.30 ----------------
   item_type    s3_item_ff;
   logic [30:0] s3_m_ff, s3_m_in;
   logic [5:0]  s3_e_ff, s3_e_in;
   logic [5:0]  pos;
   logic [62:0] norm;

   always_comb begin
      pos = '0;
      for (int b = 0; b < 63; b++) begin
         if (s2_v_ff[b]) pos = 6'(b);
      end
      if (pos >= 6'd30) norm = s2_v_ff >> (pos - 6'd30);
      else              norm = s2_v_ff << (6'd30 - pos);
      s3_m_in = norm[30:0];
      s3_e_in = 6'd62 - pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_item_ff.valid <= 1'b0;
      end else if (en) begin
         s3_item_ff <= s2_item_ff;
         s3_m_ff    <= s3_m_in;
         s3_e_ff    <= s3_e_in;
      end
   end

   // ---------------- log2 fraction, one bit per stage ----------------
   item_type    lg_item_src [0:LOG_ITERS];
   logic [30:0] lg_m_src    [0:LOG_ITERS];
   logic [27:0] lg_frac_src [0:LOG_ITERS];
   logic [5:0]  lg_e_src    [0:LOG_ITERS];

   assign lg_item_src[0] = s3_item_ff;
   assign lg_m_src[0]    = s3_m_ff;
   assign lg_frac_src[0] = '0;
   assign lg_e_src[0]    = s3_e_ff;

   for (genvar k = 0; k < LOG_ITERS; k++) begin : g_log
      item_type    item_ff;
      logic [30:0] m_ff, m_in;
      logic [27:0] frac_ff, frac_in;
      logic [5:0]  e_ff;
      logic [61:0] sqr;

      always_comb begin
         sqr     = 62'(lg_m_src[k]) * 62'(lg_m_src[k]);
         frac_in = lg_frac_src[k];
         if (sqr[61]) begin
            m_in = sqr[61:31];
            frac_in[LOG_ITERS-1-k] = 1'b1;
         end else begin
            m_in = sqr[60:30];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            item_ff.valid <= 1'b0;
         end else if (en) begin
            item_ff <= lg_item_src[k];
            m_ff    <= m_in;
            frac_ff <= frac_in;
            e_ff    <= lg_e_src[k];
         end
      end

      assign lg_item_src[k+1] = item_ff;
      assign lg_m_src[k+1]    = m_ff;
      assign lg_frac_src[k+1] = frac_ff;
      assign lg_e_src[k+1]    = e_ff;
   end

   // ---------------- w = -log2(v) * ln2, Q.28 ----------------
   item_type    w1_item_ff, w2_item_ff, w3_item_ff;
   logic [33:0] w1_nl_ff, w1_nl_in;
   logic [63:0] w2_prod_ff, w2_prod_in;
   logic [32:0] w3_w_ff, w3_w_in;
   logic [63:0] w_round;

   always_comb begin
      w1_nl_in   = {lg_e_src[LOG_ITERS], 28'd0} - {6'd0, lg_frac_src[LOG_ITERS]};
      w2_prod_in = 64'(w1_nl_ff) * 64'(LN2_Q30);
      w_round    = w2_prod_ff + (64'd1 << 29);
      w3_w_in    = w_round[62:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_item_ff.valid <= 1'b0;
         w2_item_ff.valid <= 1'b0;
         w3_item_ff.valid <= 1'b0;
      end else if (en) begin
         w1_item_ff <= lg_item_src[LOG_ITERS];
         w1_nl_ff   <= w1_nl_in;
         w2_item_ff <= w1_item_ff;
         w2_prod_ff <= w2_prod_in;
         w3_item_ff <= w2_item_ff;
         w3_w_ff    <= w3_w_in;
      end
   end

   // ---------------- branch select and square root of w ----------------
   horner_type  sq_hd_src  [0:SQRT_ITERS];
   logic [63:0] sq_n_src   [0:SQRT_ITERS];
   logic [63:0] sq_res_src [0:SQRT_ITERS];
   logic signed [33:0] t_small;

   always_comb begin
      t_small = $signed({3'd0, w3_w_ff[32:2]}) - HALF5_Q26;
      sq_hd_src[0].item = w3_item_ff;
      sq_hd_src[0].big  = (w3_w_ff >= FIVE_Q28);
      sq_hd_src[0].t    = t_small[TW-1:0];
   end

   assign sq_n_src[0]   = {7'd0, w3_w_ff, 24'd0};
   assign sq_res_src[0] = '0;

   for (genvar j = 0; j < SQRT_ITERS; j++) begin : g_sqrt
      horner_type  hd_ff;
      logic [63:0] n_ff, n_in;
      logic [63:0] res_ff, res_in;
      logic [63:0] trial;
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);

      always_comb begin
         trial = sq_res_src[j] + BIT;
         if (sq_n_src[j] >= trial) begin
            n_in   = sq_n_src[j] - trial;
            res_in = (sq_res_src[j] >> 1) + BIT;
         end else begin
            n_in   = sq_n_src[j];
            res_in = sq_res_src[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hd_ff.item.valid <= 1'b0;
         end else if (en) begin
            hd_ff  <= sq_hd_src[j];
            n_ff   <= n_in;
            res_ff <= res_in;
         end
      end

      assign sq_hd_src[j+1]  = hd_ff;
      assign sq_n_src[j+1]   = n_ff;
      assign sq_res_src[j+1] = res_ff;
   end

   // ---------------- polynomial variable and first coefficient ----------------
   horner_type         hz_hd_ff, hz_hd_in;
   logic signed [PW-1:0] hz_p_ff, hz_p_in;
   logic signed [29:0] t_large;
   logic [63:0]        sq_res_end;

   always_comb begin
      sq_res_end = sq_res_src[SQRT_ITERS];
      t_large    = $signed({1'b0, sq_res_end[28:0]}) - THREE_Q26;
      hz_hd_in   = sq_hd_src[SQRT_ITERS];
      if (hz_hd_in.big) hz_hd_in.t = t_large[TW-1:0];
      hz_p_in = hz_hd_in.big ? LARGE_COEF[0] : SMALL_COEF[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_hd_ff.item.valid <= 1'b0;
      end else if (en) begin
         hz_hd_ff <= hz_hd_in;
         hz_p_ff  <= hz_p_in;
      end
   end

   // ---------------- Horner chain ----------------
   horner_type           hn_hd [0:HORNER_STEPS];
   logic signed [PW-1:0] hn_p  [0:HORNER_STEPS];

   assign hn_hd[0] = hz_hd_ff;
   assign hn_p[0]  = hz_p_ff;

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
      erfinv_horner_step u_step (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .hd_in      (hn_hd[i]),
         .p_in       (hn_p[i]),
         .coef_small (SMALL_COEF[i+1]),
         .coef_large (LARGE_COEF[i+1]),
         .hd_out     (hn_hd[i+1]),
         .p_out      (hn_p[i+1])
      );
   end

   // ---------------- scale by x, round, saturate ----------------
   item_type              f1_item_ff;
   logic signed [2*XW-1:0] f1_prod_ff, f1_prod_in;
   logic signed [RW-1:0]  p_ext, p28, r_ext, r_rnd;
   // p in Q.28 stays below 4.5 * 2^28, so 32 bits hold it
   logic signed [XW-1:0]  p28_n;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_sat_ff;
   logic                  rsp_valid_ff;
   item_type              fin_item;

   always_comb begin
      p_ext      = RW'(hn_p[HORNER_STEPS]);
      p28        = round_shift(p_ext, 7'd4);
      p28_n      = p28[XW-1:0];
      f1_prod_in = (2*XW)'(p28_n) * (2*XW)'(hn_hd[HORNER_STEPS].item.x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_item_ff.valid <= 1'b0;
      end else if (en) begin
         f1_item_ff <= hn_hd[HORNER_STEPS].item;
         f1_prod_ff <= f1_prod_in;
      end
   end

   always_comb begin
      fin_item = f1_item_ff;
      r_ext    = RW'(f1_prod_ff);
      r_rnd    = round_shift(r_ext, 7'd31);
      if (fin_item.sat)                    rsp_data_in = MINUS_ONE;
      else if (r_rnd > RW'(INT_MAX))       rsp_data_in = INT_MAX;
      else if (r_rnd < RW'(INT_MIN))       rsp_data_in = INT_MIN;
      else                                 rsp_data_in = r_rnd[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fin_item.valid;
         rsp_data_ff  <= rsp_data_in;
         rsp_sat_ff   <= fin_item.sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // ---------------- checks ----------------
   logic lg_end_live;
   logic sq_end_valid;
   logic fin_live;

   assign lg_end_live  = lg_item_src[LOG_ITERS].valid && !lg_item_src[LOG_ITERS].sat;
   assign sq_end_valid = sq_hd_src[SQRT_ITERS].item.valid;
   assign fin_live     = en && fin_item.valid && !fin_item.sat;

`include "assert_macros.svh"

   `ERF_ASSERT(a_sat_value, rsp_tvalid && rsp_tuser |-> rsp_tdata == MINUS_ONE, "bad sat value")
   `ERF_ASSERT(a_log_norm, lg_end_live |-> lg_m_src[LOG_ITERS][30], "log mantissa left [1,2)")
   `ERF_ASSERT(a_sqrt_range, sq_end_valid |-> sq_res_end[63:29] == '0, "sqrt out of range")
   `ERF_ASSERT_NEXT(a_sign, fin_live, rsp_tdata == '0 || rsp_tdata[31] == $past(fin_item.x[31]), "sign")

endmodule
`default_nettype wire

// File: test/inverse_error_function_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_error_function_core_test
// Streams Q0.31 arguments through the erfinv core and compares each Q3.28
// result and saturation flag against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module inverse_error_function_core_test;
   import erfinv_pkg::*;

   localparam int LATENCY = 85;

   typedef struct {
      logic [31:0] x;
      logic        known;
      logic [31:0] r;
      logic        sat;
   } vec_type;

   typedef struct {
      logic [31:0] r;
      logic        sat;
   } erf_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   wire         req_tready;
   logic [31:0] req_tdata;
   wire         rsp_tvalid;
   logic        rsp_tready;
   wire  [31:0] rsp_tdata;
   wire         rsp_tuser;

   erf_type     erf_queue[$];
   int          errors = 0;
   int          results = 0;
   int          sat_seen = 0;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          hold_cycles = 0;

   inverse_error_function_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("simulation failed");
      $finish;
   end

   function automatic longint rnd_shift(longint v, int s);
      longint unsigned half;
      longint unsigned mag;
      half = 64'd1 << (s - 1);
      if (v < 0) begin
         mag = -v;
         return -longint'((mag + half) >> s);
      end
      return longint'((longint'(v) + half) >> s);
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res;
      longint unsigned bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= res + bit_w) begin
            n -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   // -ln(v), v in unsigned Q0.62, result Q.28
   function automatic longint neg_ln(longint unsigned v);
      int lead;
      longint unsigned m;
      longint unsigned frac;
      longint unsigned nl2;
      lead = 0;
      frac = 0;
      for (int b = 0; b < 63; b++) if (v[b]) lead = b;
      m = (lead >= 30) ? v >> (lead - 30) : v << (30 - lead);
      for (int i = 27; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m >>= 1;
            frac |= 64'd1 << i;
         end
      end
      nl2 = (longint'(62 - lead) << 28) - frac;
      return longint'((nl2 * 64'd744261118 + (64'd1 << 29)) >> 30);
   endfunction

   function automatic erf_type erfinv_of(logic [31:0] raw);
      erf_type o;
      longint x, w, t, p, r;
      longint unsigned mag;
      logic big;
      if (raw == MINUS_ONE) begin
         o.r = 32'h8000_0000;
         o.sat = 1'b1;
         return o;
      end
      x = longint'($signed(raw));
      mag = (x < 0) ? -x : x;
      w = neg_ln((64'd1 << 62) - mag * mag);
      big = (w >= (longint'(5) << 28));
      if (!big) t = (w >>> 2) - (longint'(5) << 25);
      else t = longint'(root64(longint'(w) << 24)) - (longint'(3) << 26);
      p = big ? longint'(LARGE_COEF[0]) : longint'(SMALL_COEF[0]);
      for (int i = 1; i <= HORNER_STEPS; i++)
         p = (big ? longint'(LARGE_COEF[i]) : longint'(SMALL_COEF[i]))
             + rnd_shift(p * t, 26);
      r = rnd_shift(rnd_shift(p, 4) * x, 31);
      if (r > 64'sh7fff_ffff) r = 64'sh7fff_ffff;
      if (r < -64'sh8000_0000) r = -64'sh8000_0000;
      o.r = r[31:0];
      o.sat = 1'b0;
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   // receiver and checker
   always @(posedge clock) begin
      erf_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results++;
            if (erf_queue.size() == 0) begin
               report("unexpected result", rsp_tdata, 32'h0);
            end else begin
               e = erf_queue.pop_front();
               if (rsp_tdata !== e.r) report("inv_erf", rsp_tdata, e.r);
               if (rsp_tuser !== e.sat) report("saturated", 32'(rsp_tuser), 32'(e.sat));
               if (e.sat) sat_seen++;
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic send(logic [31:0] x, logic known, logic [31:0] r, logic s);
      erf_type e;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= x;
      e = erfinv_of(x);
      if (known && (e.r !== r || e.sat !== s)) report("predictor table row", e.r, r);
      erf_queue.push_back(e);
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] rand_arg();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h7fff_ffff - $urandom_range(65535);
         2: return 32'h8000_0001 + $urandom_range(65535);
         3: return $urandom_range(255) - 128;
         4: return MINUS_ONE;
         default: return {$urandom_range(1) ? 2'b01 : 2'b10, 30'($urandom())};
      endcase
   endfunction

   vec_type table_rows[16] = '{
      '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
      '{32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0001, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{32'hffff_ffff, 1'b0, 32'h0, 1'b0},
      '{32'h4000_0000, 1'b0, 32'h0, 1'b0},
      '{32'hc000_0000, 1'b0, 32'h0, 1'b0},
      '{32'h6000_0000, 1'b0, 32'h0, 1'b0},
      '{32'h7800_0000, 1'b0, 32'h0, 1'b0},
      '{32'h7f00_0000, 1'b0, 32'h0, 1'b0},
      '{32'h7ff0_0000, 1'b0, 32'h0, 1'b0},
      '{32'h8010_0000, 1'b0, 32'h0, 1'b0},
      '{32'h5555_5555, 1'b0, 32'h0, 1'b0},
      '{32'haaaa_aaaa, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1}
   };

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (erf_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i])
         send(table_rows[i].x, table_rows[i].known, table_rows[i].r, table_rows[i].sat);

      // long receiver stall while requests keep coming: pipe fills, input stalls
      hold_cycles = 300;
      for (int i = 0; i < 150; i++) send(rand_arg(), 1'b0, '0, 1'b0);
      // sender waits until everything is back
      drain();

      send_idle = 22;
      recv_idle = 73;
      for (int i = 0; i < 630; i++) send(rand_arg(), 1'b0, '0, 1'b0);
      send_idle = 73;
      recv_idle = 22;
      for (int i = 0; i < 630; i++) send(rand_arg(), 1'b0, '0, 1'b0);
      send_idle = 0;
      recv_idle = 0;
      for (int i = 0; i < 500; i++) send(rand_arg(), 1'b0, '0, 1'b0);

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d results, %0d saturated; small and large branches, stalls",
               results, sat_seen);
      if (errors == 0 && erf_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
